@@ sv/rn_pkg.sv @@
`default_nettype none

package rn_pkg;

    localparam int NUM_BITS_DEF = 64;
    localparam int DEN_BITS_DEF = 32;

    localparam logic CMD_MAKE_TIME = 1'b0;
    localparam logic CMD_NORMALIZE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_REM0 = 6'b000010,
        ST_EUCL = 6'b000100,
        ST_DIVN = 6'b001000,
        ST_DIVD = 6'b010000,
        ST_FIN  = 6'b100000
    } rn_state_t;

endpackage

`default_nettype wire

@@ sv/rational_normalizer.sv @@
`default_nettype none

// Reduces numerator/denominator to lowest terms with a positive denominator; the sign goes to
// the numerator, a zero numerator gives 0/1, and a zero denominator gives 0/1 under the plain
// normalize command or is taken as 1 under make-time. A numerator of -2^(NUM_BITS-1) is first
// saturated to -(2^(NUM_BITS-1)-1). One request at a time: all arithmetic runs through a single
// one-bit-per-cycle restoring divider. A request first takes numerator mod denominator, then
// runs further Euclid steps (up to about 1.44*DEN_BITS steps) until a remainder is zero, then
// divides both parts by the last divisor, the gcd. in_ready is high only between requests; the
// result register holds the previous result while the next request is taken.
module rational_normalizer #(
    parameter int NUM_BITS = rn_pkg::NUM_BITS_DEF,
    parameter int DEN_BITS = rn_pkg::DEN_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       command,
    input  wire logic signed [NUM_BITS-1:0] numerator,
    input  wire logic signed [DEN_BITS-1:0] denominator,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [NUM_BITS-1:0]      reduced_numerator,
    output logic        [DEN_BITS-1:0]      reduced_denominator
);
    import rn_pkg::*;

    localparam int W  = (NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS;
    localparam int CW = $clog2(W + 1);

    rn_state_t             state_reg, state_next;
    logic [W-1:0]          q_reg, q_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0]   dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]   nmag_reg, nmag_next;
    logic [DEN_BITS-1:0]   dmag_reg, dmag_next;
    logic                  neg_reg, neg_next;
    logic [NUM_BITS-1:0]   rnum_reg, rnum_next;
    logic [DEN_BITS-1:0]   rden_reg, rden_next;
    logic                  oval_reg, oval_next;
    logic [NUM_BITS-1:0]   onum_reg, onum_next;
    logic [DEN_BITS-1:0]   oden_reg, oden_next;

    // divider step
    logic [DEN_BITS:0]     sh;
    logic [DEN_BITS:0]     diff;
    logic                  ge;
    logic [DEN_BITS-1:0]   rem_step;
    logic [W-1:0]          q_step;
    logic                  last;

    // input decode
    logic                  nneg, dneg;
    logic [NUM_BITS-1:0]   nabs, nsat;
    logic [DEN_BITS-1:0]   dabs;

    assign in_ready            = (state_reg == ST_IDLE);
    assign out_valid           = oval_reg;
    assign reduced_numerator   = onum_reg;
    assign reduced_denominator = oden_reg;

    always_comb
    begin
        sh       = {rem_reg, q_reg[W-1]};
        diff     = sh - {1'b0, dvs_reg};
        ge       = !diff[DEN_BITS];
        rem_step = ge ? diff[DEN_BITS-1:0] : sh[DEN_BITS-1:0];
        q_step   = {q_reg[W-2:0], ge};
        last     = (cnt_reg == CW'(1));

        nneg = numerator[NUM_BITS-1];
        dneg = denominator[DEN_BITS-1];
        nabs = nneg ? NUM_BITS'(-numerator) : NUM_BITS'(numerator);
        nsat = nabs[NUM_BITS-1] ? {1'b0, {(NUM_BITS-1){1'b1}}} : nabs;
        dabs = dneg ? DEN_BITS'(-denominator) : DEN_BITS'(denominator);
    end

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        nmag_next  = nmag_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        oval_next  = oval_reg;
        onum_next  = onum_reg;
        oden_next  = oden_reg;

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    nmag_next = nsat;
                    dmag_next = (dabs == '0) ? DEN_BITS'(1) : dabs;
                    neg_next  = nneg ^ (dneg && dabs != '0);
                    rnum_next = '0;
                    rden_next = DEN_BITS'(1);
                    if ((dabs == '0 && command == CMD_NORMALIZE) || nsat == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        q_next     = W'(nsat) << (W - NUM_BITS);
                        rem_next   = '0;
                        dvs_next   = (dabs == '0) ? DEN_BITS'(1) : dabs;
                        cnt_next   = CW'(NUM_BITS);
                        state_next = ST_REM0;
                    end
                end
            end
            ST_REM0, ST_EUCL, ST_DIVN, ST_DIVD:
            begin
                q_next   = q_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    rem_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        rnum_next  = q_step[NUM_BITS-1:0];
                        q_next     = W'(dmag_reg) << (W - DEN_BITS);
                        cnt_next   = CW'(DEN_BITS);
                        state_next = ST_DIVD;
                    end
                    else if (state_reg == ST_DIVD)
                    begin
                        rden_next  = q_step[DEN_BITS-1:0];
                        state_next = ST_FIN;
                    end
                    else if (rem_step == '0)
                    begin
                        // divisor is the gcd
                        q_next     = W'(nmag_reg) << (W - NUM_BITS);
                        cnt_next   = CW'(NUM_BITS);
                        state_next = ST_DIVN;
                    end
                    else
                    begin
                        q_next     = W'(dvs_reg) << (W - DEN_BITS);
                        dvs_next   = rem_step;
                        cnt_next   = CW'(DEN_BITS);
                        state_next = ST_EUCL;
                    end
                end
            end
            ST_FIN:
            begin
                if (!oval_reg || out_ready)
                begin
                    oval_next  = 1'b1;
                    onum_next  = neg_reg ? NUM_BITS'(-rnum_reg) : rnum_reg;
                    oden_next  = rden_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        onum_reg <= onum_next;
        oden_reg <= oden_next;
    end

endmodule

`default_nettype wire
